>>> design/lps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg
// Shared widths, operation and status codes, and the cell control type for
// the positional list store.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int DEFAULT_CAPACITY = 64;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_FWD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_BWD = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROT_FWD,
    CMD_ROT_BWD
  } cell_cmd_t;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    cell_cmd_t                  cmd;
    logic [POS_W-1:0]           pos;
    logic [POS_W-1:0]           count;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> design/lps_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_in_if / lps_out_if
// Valid/ready channels for operation requests and for results.
// ----------------------------------------------------------------------------
interface lps_in_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 mode;
  logic signed [31:0]         value;
  logic [6:0]                 position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface lps_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [31:0]         element;
  logic                       last;
  logic [1:0]                 status;
  logic [6:0]                 count;

  modport source (output valid, output element, output last, output status, output count,
                  input ready);
  modport sink   (input valid, input element, input last, input status, input count,
                  output ready);
endinterface
`default_nettype wire

>>> design/positional_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to CAPACITY signed values kept in a chain of cells.
// Append, insert and remove shift the cells; read-outs rotate
// the held part of the chain past the output.
// ----------------------------------------------------------------------------
// Append, insert, remove: the single result is registered when the op is accepted.
// Read-out: after the accept, one result per cycle while the output is free,
// the chain rotating one slot per result; an empty one gives ST_EMPTY.
// rst_n (synchronous) empties the list and drops any pending result; the
// element cells themselves are not reset.
module positional_list_store #(
  parameter int CAPACITY = lps_pkg::DEFAULT_CAPACITY
) (
  input  wire        clk,
  input  wire        rst_n,
  lps_in_if.sink     in_ch,
  lps_out_if.source  out_ch
);
  import lps_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             rem_r, rem_nxt;
  logic                      dir_bwd_r, dir_bwd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_elem_r, out_elem_nxt;
  logic                      out_last_r, out_last_nxt;
  logic [STAT_W-1:0]         out_stat_r, out_stat_nxt;
  logic [COUNT_W-1:0]        out_cnt_r, out_cnt_nxt;

  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] cell_data [CAPACITY];
  logic signed [VALUE_W-1:0] tail_data;
  logic [POS_W-1:0]          cnt_ext;
  logic                      out_free;
  logic                      in_ready;
  logic                      in_xfer;

  assign cnt_ext   = POS_W'(cnt_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_xfer   = in_ch.valid && in_ready;
  assign tail_data = cell_data[AW'(cnt_r - CW'(1))];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      lps_cell #(.IDX(g)) u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .prev_i ((g == 0) ? 32'sd0 : cell_data[(g == 0) ? 0 : g - 1]),
        .next_i ((g == CAPACITY - 1) ? 32'sd0 : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
        .head_i (cell_data[0]),
        .tail_i (tail_data),
        .data_o (cell_data[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dir_bwd_nxt   = dir_bwd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    ctrl.cmd      = CMD_HOLD;
    ctrl.pos      = in_ch.position;
    ctrl.count    = cnt_ext;
    ctrl.value    = in_ch.value;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = ST_OK;
          case (in_ch.mode)
            MODE_APPEND: begin
              if (cnt_r == CAP_CNT) begin
                out_stat_nxt = ST_FULL;
              end else begin
                ctrl.cmd = CMD_INSERT;
                ctrl.pos = cnt_ext;
                cnt_nxt  = cnt_r + CW'(1);
              end
            end
            MODE_INSERT: begin
              if (in_ch.position > cnt_ext) begin
                out_stat_nxt = ST_RANGE;
              end else if (cnt_r == CAP_CNT) begin
                out_stat_nxt = ST_FULL;
              end else begin
                ctrl.cmd = CMD_INSERT;
                cnt_nxt  = cnt_r + CW'(1);
              end
            end
            MODE_REMOVE: begin
              if (in_ch.position >= cnt_ext) begin
                out_stat_nxt = ST_RANGE;
              end else begin
                ctrl.cmd = CMD_REMOVE;
                cnt_nxt  = cnt_r - CW'(1);
              end
            end
            MODE_READ_FWD, MODE_READ_BWD: begin
              if (cnt_r == '0) begin
                out_stat_nxt = ST_EMPTY;
              end else begin
                // Results come from the read state, one per rotation step.
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                rem_nxt       = cnt_r;
                dir_bwd_nxt   = (in_ch.mode == MODE_READ_BWD);
              end
            end
            default: out_stat_nxt = ST_OK;
          endcase
          out_cnt_nxt = COUNT_W'(cnt_nxt);
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = dir_bwd_r ? tail_data : cell_data[0];
          out_last_nxt  = (rem_r == CW'(1));
          out_stat_nxt  = ST_OK;
          out_cnt_nxt   = COUNT_W'(cnt_r);
          ctrl.cmd      = dir_bwd_r ? CMD_ROT_BWD : CMD_ROT_FWD;
          rem_nxt       = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      dir_bwd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      dir_bwd_r   <= dir_bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.element = out_elem_r;
  assign out_ch.last    = out_last_r;
  assign out_ch.status  = out_stat_r;
  assign out_ch.count   = out_cnt_r;

endmodule
`default_nettype wire

>>> design/lps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_cell
// One list slot. Holds the element at index IDX and, on command, loads the
// new value or takes a neighbor's element to shift or rotate the list.
// ----------------------------------------------------------------------------
module lps_cell #(
  parameter int IDX = 0
) (
  input  wire                          clk,
  input  wire lps_pkg::cell_ctrl_t     ctrl,
  input  wire signed [31:0]            prev_i,
  input  wire signed [31:0]            next_i,
  input  wire signed [31:0]            head_i,
  input  wire signed [31:0]            tail_i,
  output logic signed [31:0]           data_o
);
  import lps_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX  = POS_W'(IDX);
  localparam logic [POS_W-1:0] MY_IDX1 = POS_W'(IDX + 1);

  logic signed [VALUE_W-1:0] data_r;
  logic signed [VALUE_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (MY_IDX == ctrl.pos) begin
          data_nxt = ctrl.value;
        end else if (MY_IDX > ctrl.pos && MY_IDX <= ctrl.count) begin
          data_nxt = prev_i;
        end
      end
      CMD_REMOVE: begin
        if (MY_IDX >= ctrl.pos && MY_IDX1 < ctrl.count) begin
          data_nxt = next_i;
        end
      end
      CMD_ROT_FWD: begin
        // The front element wraps around to the last held slot.
        if (MY_IDX1 < ctrl.count) begin
          data_nxt = next_i;
        end else if (MY_IDX1 == ctrl.count) begin
          data_nxt = head_i;
        end
      end
      CMD_ROT_BWD: begin
        if (IDX == 0) begin
          data_nxt = tail_i;
        end else if (MY_IDX < ctrl.count) begin
          data_nxt = prev_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule
`default_nettype wire

>>> dv/tb_positional_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_positional_list_store
// Self-checking bench for the positional list store. A scoreboard keeps its
// own copy of the list, predicts every result of each accepted operation and
// checks the result stream in order. The stimulus is a directed opening,
// then random mixes, then a fill to capacity, full-list rejections, and a drain.
// Both channels idle at random, except in the final stretch.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
  import lps_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic                      last;
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  class list_scoreboard;
    int                        capacity;
    logic signed [VALUE_W-1:0] held[$];
    list_result_t              expected[$];
    int                        errors;
    int                        n_ops;
    int                        n_checked;
    int                        n_reads;
    int                        n_full;
    int                        n_range;
    int                        n_empty;

    function new(int cap);
      capacity  = cap;
      errors    = 0;
      n_ops     = 0;
      n_checked = 0;
      n_reads   = 0;
      n_full    = 0;
      n_range   = 0;
      n_empty   = 0;
    endfunction

    function int fill();
      return held.size();
    endfunction

    function int outstanding();
      return expected.size();
    endfunction

    // Applies one accepted operation to the list copy and queues its results.
    function void note_input(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value,
                             logic [POS_W-1:0] pos);
      list_result_t r;
      int           cnt;
      int           idx;
      logic [STAT_W-1:0] st;
      cnt = held.size();
      st  = ST_OK;
      n_ops++;
      if (mode == MODE_READ_FWD || mode == MODE_READ_BWD) begin
        n_reads++;
        if (cnt == 0) begin
          n_empty++;
          r = '{element: '0, last: 1'b1, status: ST_EMPTY, count: '0};
          expected.push_back(r);
        end else begin
          for (int i = 0; i < cnt; i++) begin
            idx = (mode == MODE_READ_FWD) ? i : cnt - 1 - i;
            r.element = held[idx];
            r.last    = (i == cnt - 1);
            r.status  = ST_OK;
            r.count   = COUNT_W'(cnt);
            expected.push_back(r);
          end
        end
        return;
      end
      case (mode)
        MODE_APPEND: begin
          if (cnt >= capacity) st = ST_FULL;
          else held.push_back(value);
        end
        MODE_INSERT: begin
          // The range check takes precedence over the full check.
          if (int'(pos) > cnt) st = ST_RANGE;
          else if (cnt >= capacity) st = ST_FULL;
          else held.insert(int'(pos), value);
        end
        MODE_REMOVE: begin
          if (int'(pos) >= cnt) st = ST_RANGE;
          else held.delete(int'(pos));
        end
        default: ;
      endcase
      if (st == ST_FULL) n_full++;
      if (st == ST_RANGE) n_range++;
      r = '{element: '0, last: 1'b1, status: st, count: COUNT_W'(held.size())};
      expected.push_back(r);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] element, logic last,
                               logic [STAT_W-1:0] status, logic [COUNT_W-1:0] count);
      list_result_t e;
      n_checked++;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch %0d: result with none expected (element %0d last %0b %s",
                   errors, element, last, $sformatf("st %0d cnt %0d)", status, count));
        return;
      end
      e = expected.pop_front();
      if (element !== e.element || last !== e.last || status !== e.status ||
          count !== e.count) begin
        errors++;
        if (errors <= 10)
          $display("mismatch %0d: element exp %0d got %0d, last exp %0b got %0b, %s",
                   errors, e.element, element, e.last, last,
                   $sformatf("st exp %0d got %0d, cnt exp %0d got %0d",
                             e.status, status, e.count, count));
      end
    endfunction
  endclass

  localparam int CAP        = DEFAULT_CAPACITY;
  localparam int POS_MAX    = (1 << POS_W) - 1;
  localparam int LIMIT      = 1_000_000;
  localparam int DRAIN_WAIT = 16;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  bit   src_idle_on;
  bit   sink_idle_on;
  int   stall_left;

  lps_in_if  in_ch();
  lps_out_if out_ch();

  list_scoreboard sb = new(CAP);

  positional_list_store #(.CAPACITY(CAP)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.element, out_ch.last, out_ch.status, out_ch.count);
  end

  // Result side back-pressure: random stall bursts while enabled.
  initial begin
    out_ch.ready <= 1'b1;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!sink_idle_on) begin
        stall_left = 0;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Valid stays high from one transfer to the next unless a gap is taken.
  task automatic send_op(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v,
                         input logic [POS_W-1:0] p);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= m;
    in_ch.value    <= v;
    in_ch.position <= p;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(m, v, p);
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic mixed_op();
    int                        cnt;
    int                        pick;
    logic [MODE_W-1:0]         m;
    logic signed [VALUE_W-1:0] v;
    logic [POS_W-1:0]          p;
    cnt  = sb.fill();
    pick = $urandom_range(0, 99);
    v    = rand_value();
    p    = '0;
    if (pick < 25) begin
      m = MODE_APPEND;
    end else if (pick < 50) begin
      m = MODE_INSERT;
      p = POS_W'($urandom_range(0, cnt));
    end else if (pick < 78) begin
      m = MODE_REMOVE;
      p = (cnt == 0) ? '0 : POS_W'($urandom_range(0, cnt - 1));
    end else if (pick < 84) begin
      m = MODE_READ_FWD;
    end else if (pick < 90) begin
      m = MODE_READ_BWD;
    end else if (pick < 95) begin
      m = $urandom_range(0, 1) ? MODE_INSERT : MODE_REMOVE;
      p = POS_W'($urandom_range(0, POS_MAX));
    end else begin
      m = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      p = POS_W'($urandom_range(0, POS_MAX));
    end
    send_op(m, v, p);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_APPEND;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty list, range errors, extremes, unused modes.
    send_op(MODE_READ_FWD, '0, '0);
    send_op(MODE_READ_BWD, '0, '0);
    send_op(MODE_REMOVE, '0, 7'd0);
    send_op(MODE_INSERT, 32'd5, 7'd1);
    send_op(MODE_INSERT, 32'd6, 7'(POS_MAX));
    send_op(MODE_APPEND, 32'h7FFF_FFFF, '0);
    send_op(MODE_APPEND, 32'h8000_0000, '1);
    send_op(MODE_INSERT, '0, 7'd0);
    send_op(MODE_INSERT, '1, 7'd3);
    send_op(MODE_INSERT, 32'h5555_5555, 7'd2);
    send_op(MODE_INSERT, 32'd9, 7'd6);
    send_op(MODE_READ_FWD, '0, '0);
    send_op(MODE_READ_BWD, '0, '0);
    send_op(MODE_REMOVE, '0, 7'd5);
    send_op(MODE_REMOVE, '0, 7'd0);
    send_op(MODE_REMOVE, '0, 7'd3);
    send_op(MODE_REMOVE, '0, 7'd1);
    send_op(MODE_SPARE_FIRST, 32'd1, 7'd1);
    send_op(MODE_SPARE_MID, 32'd2, 7'd0);
    send_op(MODE_SPARE_LAST, '1, '1);
    send_op(MODE_READ_FWD, '0, '0);
    send_op(MODE_APPEND, 32'hAAAA_AAAA, '0);

    repeat (70) mixed_op();
    wait_quiet();

    // Grow to capacity, then hit the full and range checks on a full list.
    while (sb.fill() < CAP) begin
      if ($urandom_range(0, 1))
        send_op(MODE_APPEND, rand_value(), 7'($urandom));
      else
        send_op(MODE_INSERT, rand_value(), 7'($urandom_range(0, sb.fill())));
    end
    send_op(MODE_APPEND, rand_value(), '0);
    send_op(MODE_INSERT, rand_value(), 7'($urandom_range(0, CAP)));
    send_op(MODE_INSERT, rand_value(), 7'(CAP + 1));
    send_op(MODE_INSERT, rand_value(), 7'(POS_MAX));
    send_op(MODE_READ_FWD, '0, '0);
    send_op(MODE_READ_BWD, '0, '0);
    send_op(MODE_REMOVE, '0, 7'(CAP));
    while (sb.fill() > 8)
      send_op(MODE_REMOVE, rand_value(), 7'($urandom_range(0, sb.fill() - 1)));
    wait_quiet();

    // Final stretch at full rate on both sides.
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (50) mixed_op();
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d operations (%0d read-outs, %0d of them empty), checked %0d results",
             sb.n_ops, sb.n_reads, sb.n_empty, sb.n_checked);
    $display("rejections seen: %0d out of range, %0d list full; %0d mismatches",
             sb.n_range, sb.n_full, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
